### design/clock_page_replacement_unit_macros.svh
// assertion macros for the clock page replacement unit
`ifndef CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH
// assert that an antecedent implies a consequent in the same cycle
`define CPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/cpr_pkg.sv
// shared constants and types of the clock page replacement unit
package cpr_pkg;
	localparam int Frames = 16;
	localparam int VirtualPages = 64;
	localparam int PageBytes = 1024;
	localparam int Processes = 16;
	localparam int FW = $clog2(Frames);
	localparam int VPW = $clog2(VirtualPages);
	localparam int OFFW = $clog2(PageBytes);
	localparam int PW = $clog2(Processes);
	localparam int PTW = PW + VPW;
	localparam int PtDepth = Processes * VirtualPages;

	localparam logic [1:0] StHit = 2'd0;
	localparam logic [1:0] StFree = 2'd1;
	localparam logic [1:0] StEvict = 2'd2;
	localparam logic [1:0] StRelease = 2'd3;

	localparam logic CmdAccess = 1'b0;
	localparam logic CmdRelease = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch the input transaction
		logic clr_scan;   // reset scan index and hand step count to zero
		logic scan_inc;   // advance scan index
		logic pt_rd;      // read page table for the request
		logic rel_step;   // release current scan frame if owned
		logic hand_step;  // examine hand frame, clear ref, advance
		logic fill;       // install page into chosen frame
		logic hit;        // set reference of hit frame
		logic set_out;    // load output register
		logic [1:0] status;
	} cpr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_release;
		logic pt_hit;
		logic scan_last;
		logic scan_free;  // frame at scan index is free
		logic any_free;
		logic hand_victim;  // valid frame with clear ref at hand
		logic hand_count_done;
	} cpr_sts_t;
endpackage

### design/clock_page_replacement_unit.sv
// top level: clock second-chance page replacement unit
// a transaction ends as a hit, a free-frame miss (lowest free frame searched
// one frame a cycle), a release or an eviction
// one transaction at a time: the next is accepted from the cycle after the result is
// loaded, a stalled result holds the unit
// arst_n clears all frames, page residency and the clock hand
module clock_page_replacement_unit
	import cpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [3:0]  proc_id,
	input  logic [15:0] virtual_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  frame_number,
	output logic [13:0] physical_address,
	output logic [3:0]  victim_process,
	output logic [5:0]  victim_page
);
	cpr_cmd_t cmd;
	cpr_sts_t sts;

	cpr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(in_valid && in_ready),
		.out_busy(out_valid && !out_ready),
		.sts, .in_rdy(in_ready), .cmd
	);

	cpr_dp u_dp (
		.clk, .arst_n, .command, .proc_id, .virtual_address,
		.cmd, .out_take(out_ready), .sts, .out_vld(out_valid),
		.status, .frame_number, .physical_address, .victim_process, .victim_page
	);
endmodule

### design/cpr_ctrl.sv
// controller state machine of the clock page replacement unit
module cpr_ctrl
	import cpr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_busy,
	input  cpr_sts_t sts,
	output logic     in_rdy,
	output cpr_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_PT, S_DECIDE, S_REL, S_FREE, S_HAND, S_OUT
	} state_t;
	state_t state_q;
	logic [1:0] status_q;

	assign in_rdy = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_fire;
				cmd.clr_scan = in_fire;
			end
			S_PT: cmd.pt_rd = 1'b1;
			S_DECIDE: ;
			S_REL: begin
				cmd.rel_step = 1'b1;
				cmd.scan_inc = 1'b1;
			end
			S_FREE: cmd.scan_inc = !sts.scan_free;
			S_HAND: cmd.hand_step = !sts.hand_victim && !sts.hand_count_done;
			S_OUT: begin
				cmd.set_out = !out_busy;
				cmd.fill = !out_busy && status_q != StHit && status_q != StRelease;
				cmd.hit = !out_busy && status_q == StHit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= StHit;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_PT;
				S_PT: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.is_release) begin
						status_q <= StRelease;
						state_q <= S_REL;
					end else if (sts.pt_hit) begin
						status_q <= StHit;
						state_q <= S_OUT;
					end else if (sts.any_free) begin
						status_q <= StFree;
						state_q <= S_FREE;
					end else begin
						status_q <= StEvict;
						state_q <= S_HAND;
					end
				end
				S_REL: if (sts.scan_last) state_q <= S_OUT;
				S_FREE: if (sts.scan_free) state_q <= S_OUT;
				S_HAND: if (sts.hand_victim || sts.hand_count_done) state_q <= S_OUT;
				S_OUT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/cpr_dp.sv
// datapath of the clock page replacement unit: tables, hand and output register
module cpr_dp
	import cpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              command,
	input  logic [3:0]        proc_id,
	input  logic [15:0]       virtual_address,
	input  cpr_cmd_t          cmd,
	input  logic              out_take,
	output cpr_sts_t          sts,
	output logic              out_vld,
	output logic [1:0]        status,
	output logic [3:0]        frame_number,
	output logic [13:0]       physical_address,
	output logic [3:0]        victim_process,
	output logic [5:0]        victim_page
);
	localparam int HandCntW = $clog2(2 * Frames + 3);

	// frame table in flip-flops
	logic [Frames-1:0] fvalid_q, fref_q;
	logic [PW-1:0]  fowner_q [Frames];
	logic [VPW-1:0] fpage_q  [Frames];
	// page table: frame memory, residency confirmed against the frame table
	logic [FW-1:0] ptmem [PtDepth];
	logic [FW-1:0] ptrd_q;

	logic          cmd_q;
	logic [PW-1:0] pid_q;
	logic [VPW-1:0] page_q;
	logic [OFFW-1:0] off_q;
	logic [FW-1:0] scan_q, hand_q, sel;
	logic [HandCntW-1:0] hcnt_q;
	logic [PTW-1:0] req_idx;

	assign req_idx = {pid_q, page_q};
	assign sel = (cmd.status == StEvict) ? hand_q : scan_q;

	assign sts.is_release = cmd_q;
	// resident when the recorded frame still holds this page of this process
	assign sts.pt_hit = fvalid_q[ptrd_q] && (fowner_q[ptrd_q] == pid_q)
		&& (fpage_q[ptrd_q] == page_q);
	assign sts.scan_last = (scan_q == FW'(Frames - 1));
	assign sts.scan_free = !fvalid_q[scan_q];
	assign sts.any_free = !(&fvalid_q);
	assign sts.hand_victim = fvalid_q[hand_q] && !fref_q[hand_q];
	assign sts.hand_count_done = (hcnt_q == HandCntW'(2 * Frames + 2));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			pid_q <= PW'(proc_id);
			page_q <= VPW'(virtual_address[15:OFFW]);
			off_q <= virtual_address[OFFW-1:0];
		end
		if (cmd.pt_rd) ptrd_q <= ptmem[req_idx];
		if (cmd.fill) ptmem[req_idx] <= sel;
		if (cmd.fill) begin
			fowner_q[sel] <= pid_q;
			fpage_q[sel] <= page_q;
		end
		if (cmd.set_out) begin
			status <= cmd.status;
			frame_number <= (cmd.status == StRelease) ? '0 :
				4'(cmd.status == StHit ? ptrd_q : sel);
			physical_address <= (cmd.status == StRelease) ? '0 :
				14'({(cmd.status == StHit ? ptrd_q : sel), off_q});
			victim_process <= (cmd.status == StEvict) ? 4'(fowner_q[hand_q]) : '0;
			victim_page <= (cmd.status == StEvict) ? 6'(fpage_q[hand_q]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= '0;
			fref_q <= '0;
			scan_q <= '0;
			hand_q <= '0;
			hcnt_q <= '0;
			out_vld <= 1'b0;
		end else begin
			if (cmd.clr_scan) begin
				scan_q <= '0;
				hcnt_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.rel_step && fvalid_q[scan_q] && fowner_q[scan_q] == pid_q) begin
				fvalid_q[scan_q] <= 1'b0;
				fref_q[scan_q] <= 1'b0;
			end
			if (cmd.hand_step) begin
				if (fvalid_q[hand_q]) fref_q[hand_q] <= 1'b0;
				hand_q <= (hand_q == FW'(Frames - 1)) ? '0 : hand_q + 1'b1;
				hcnt_q <= hcnt_q + 1'b1;
			end
			if (cmd.hit) fref_q[ptrd_q] <= 1'b1;
			if (cmd.fill) begin
				fvalid_q[sel] <= 1'b1;
				fref_q[sel] <= 1'b1;
			end
			if (cmd.set_out) out_vld <= 1'b1;
			else if (out_take) out_vld <= 1'b0;
		end
	end
endmodule

### design/cpr_checker.sv
// port-level checker of the clock page replacement unit
`include "clock_page_replacement_unit_macros.svh"
module cpr_checker
	import cpr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [3:0]  frame_number,
	input logic [13:0] physical_address,
	input logic [3:0]  victim_process,
	input logic [5:0]  victim_page
);
	`CPR_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`CPR_ASSERT_IMP(a_release_zero, clk, arst_n, out_valid && status == StRelease, frame_number == '0 && physical_address == '0, "release fields")
	`CPR_ASSERT_IMP(a_victim_zero, clk, arst_n, out_valid && status != StEvict, victim_process == '0 && victim_page == '0, "victim fields")
	`CPR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status), "output dropped")
endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (.*);
